// ----- hdl/fdm_pkg.sv -----
// ----------------------------------------------------------------------------
// fdm_pkg
// shared constants for the fatigue degradation mobility block
// ----------------------------------------------------------------------------
package fdm_pkg;

  // material points, a power of two so the point index wraps by truncation
  localparam int unsigned POINTS    = 1024;
  localparam int unsigned PT_W      = $clog2(POINTS);
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned IDX_W    = 10;
  localparam int unsigned Q32_W    = 32;
  localparam int unsigned FAC_W    = 17;
  localparam int unsigned SLOPE_W  = 24;
  localparam int unsigned LEVEL_W  = 40;
  localparam int unsigned ENERGY_W = 33;
  localparam int unsigned LOG_W    = 22;

  localparam logic [FAC_W-1:0]   ONE_Q     = FAC_W'(1) << FRAC_BITS;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  // log10(2) in q0.32
  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;

  // operation codes
  localparam logic OP_INIT   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SLOPE     = 2'd1;
  localparam logic [1:0] REG_MODE      = 2'd2;

  localparam logic MODE_ASYMPTOTIC = 1'b0;

endpackage

// ----- hdl/fatigue_degradation_mobility.sv -----
// ----------------------------------------------------------------------------
// fatigue_degradation_mobility
// per-point fatigue level tracking with degraded phase-field mobility
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low; its result is
// shown on the result ports for one cycle with done_o high and cannot be
// held off. One command is in work at a time. After reset a clearing pass
// zeroes the per-point state while busy_o stays high; configuration writes
// are taken at any time. An init command gives its result on the next cycle
// and can be followed at once. An update reads the point from the state
// memory at the accepting edge, passes S_MUL, S_UPD and S_DEC and raises
// done_o from S_MOB; below threshold it goes there directly, on the
// asymptotic curve through 17 steps of the restoring divider, and on the
// logarithmic curve through two normalisations of up to 12 steps and two
// logarithms of 16 squaring steps each on the shared squaring multiplier.
module fatigue_degradation_mobility (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_index_i,
  input  logic [fdm_pkg::Q32_W-1:0]            cfg_wdata_i,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 op_i,
  input  logic [fdm_pkg::IDX_W-1:0]            point_index_i,
  input  logic [fdm_pkg::Q32_W-1:0]            init_level_i,
  input  logic [fdm_pkg::Q32_W-1:0]            energy_now_i,
  input  logic [fdm_pkg::Q32_W-1:0]            energy_before_i,
  input  logic [fdm_pkg::FAC_W-1:0]            damage_factor_now_i,
  input  logic [fdm_pkg::FAC_W-1:0]            damage_factor_before_i,
  input  logic [fdm_pkg::Q32_W-1:0]            base_mobility_i,
  output logic                                 done_o,
  output logic [fdm_pkg::Q32_W-1:0]            mobility_o,
  output logic [fdm_pkg::FAC_W-1:0]            degradation_o,
  output logic [fdm_pkg::LEVEL_W-1:0]          level_o,
  output logic                                 fatigued_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_UPD, S_DEC, S_DIV, S_NORM, S_LOGSQ,
    S_D2, S_D10, S_DROP, S_FSQ, S_MOB
  } state_e;

  localparam int unsigned MEM_W = fdm_pkg::LEVEL_W + 1;

  state_e state_q;

  // configuration
  logic [fdm_pkg::Q32_W-1:0]   thr_q;
  logic [fdm_pkg::SLOPE_W-1:0] slope_q;
  logic                        mode_q;

  // state memory: flag in the top bit, level below
  logic [MEM_W-1:0]            mem [fdm_pkg::POINTS];
  logic [MEM_W-1:0]            rd_q;
  logic                        mem_we;
  logic [fdm_pkg::PT_W-1:0]    mem_wa;
  logic [MEM_W-1:0]            mem_wd;
  logic [fdm_pkg::PT_W:0]      clr_q;

  // captured command
  logic [fdm_pkg::PT_W-1:0]    idx_q;
  logic [fdm_pkg::Q32_W-1:0]   en_q, eb_q, base_q;
  logic [fdm_pkg::FAC_W-1:0]   gn_q, gb_q;

  // working registers
  logic [fdm_pkg::ENERGY_W-1:0] a_q, aold_q;
  logic [fdm_pkg::LEVEL_W-1:0]  lvl_q;
  logic                         flag_q;
  logic [48:0]                  rem_q;
  logic [40:0]                  den_q;
  logic [4:0]                   cnt_q;
  logic [fdm_pkg::FAC_W-1:0]    quo_q;
  logic [fdm_pkg::LEVEL_W-1:0]  norm_q;
  logic [5:0]                   shcnt_q;
  logic [30:0]                  m_q;
  logic [15:0]                  frac_q;
  logic                         which_q;
  logic [fdm_pkg::LOG_W-1:0]    la_q, lb_q, d2_q, d10_q;
  logic [fdm_pkg::FAC_W-1:0]    sq_q, f_q;

  // result registers
  logic                         done_q;
  logic [fdm_pkg::Q32_W-1:0]    mob_q;
  logic [fdm_pkg::FAC_W-1:0]    deg_q;
  logic [fdm_pkg::LEVEL_W-1:0]  lvo_q;
  logic                         fto_q;

  logic accept;
  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // datapath helpers
  logic [48:0] prod_a, prod_b;
  logic [fdm_pkg::ENERGY_W:0]   up_diff, dn_diff;
  logic [fdm_pkg::LEVEL_W:0]    lvl_sum;
  logic [fdm_pkg::LEVEL_W-1:0]  lvl_new;
  logic                         flag_new;
  logic [56:0]                  den_sh;
  logic                         div_ge;
  logic [61:0]                  msq;
  logic [31:0]                  msq_s;
  logic                         frac_bit;
  logic [5:0]                   p_pos;
  logic [fdm_pkg::LOG_W-1:0]    log_val;
  logic [53:0]                  d10_prod;
  logic [45:0]                  drop_prod;
  logic [29:0]                  drop;
  logic [33:0]                  fsq;
  logic [48:0]                  mob_prod;

  always_comb begin
    prod_a   = 49'(gn_q) * 49'(en_q);
    prod_b   = 49'(gb_q) * 49'(eb_q);
    up_diff  = {1'b0, a_q} - {1'b0, aold_q};
    dn_diff  = {1'b0, aold_q} - {1'b0, a_q};
    lvl_sum  = {1'b0, lvl_q} + 41'(up_diff[fdm_pkg::ENERGY_W-1:0]);
    lvl_new  = lvl_q;
    if (a_q > aold_q) begin
      lvl_new = lvl_sum[fdm_pkg::LEVEL_W] ? fdm_pkg::LEVEL_MAX
                                          : lvl_sum[fdm_pkg::LEVEL_W-1:0];
    end else if (!flag_q) begin
      lvl_new = (40'(dn_diff[fdm_pkg::ENERGY_W-1:0]) > lvl_q) ? '0
                : lvl_q - 40'(dn_diff[fdm_pkg::ENERGY_W-1:0]);
    end
    flag_new  = flag_q || (lvl_q > 40'(thr_q));
    // restoring divider step
    den_sh    = 57'(den_q) << cnt_q;
    div_ge    = (57'(rem_q) >= den_sh);
    // logarithm squaring step
    msq       = 62'(m_q) * 62'(m_q);
    msq_s     = msq[61:30];
    frac_bit  = msq_s[31];
    p_pos     = 6'd39 - shcnt_q;
    log_val   = {p_pos, frac_q[14:0], frac_bit};
    d10_prod  = 54'(d2_q) * 54'(fdm_pkg::LOG10_2_Q32);
    drop_prod = 46'(slope_q) * 46'(d10_q);
    drop      = drop_prod[45:16];
    fsq       = 34'(sq_q) * 34'(sq_q);
    mob_prod  = 49'(base_q) * 49'(f_q);
  end

  // memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wd = {flag_new, lvl_q};
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q[fdm_pkg::PT_W-1:0];
      mem_wd = '0;
    end else if (accept && (op_i == fdm_pkg::OP_INIT)) begin
      mem_we = 1'b1;
      mem_wa = point_index_i[fdm_pkg::PT_W-1:0];
      mem_wd = {1'b0, 8'b0, init_level_i};
    end else if (state_q == S_DEC) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_q <= mem[point_index_i[fdm_pkg::PT_W-1:0]];
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= 32'd65536;
      slope_q <= '0;
      mode_q  <= fdm_pkg::MODE_ASYMPTOTIC;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fdm_pkg::REG_THRESHOLD: thr_q   <= cfg_wdata_i;
        fdm_pkg::REG_SLOPE:     slope_q <= cfg_wdata_i[fdm_pkg::SLOPE_W-1:0];
        fdm_pkg::REG_MODE:      mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (fdm_pkg::PT_W+1)'(fdm_pkg::POINTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            idx_q  <= point_index_i[fdm_pkg::PT_W-1:0];
            en_q   <= energy_now_i;
            eb_q   <= energy_before_i;
            gn_q   <= damage_factor_now_i;
            gb_q   <= damage_factor_before_i;
            base_q <= base_mobility_i;
            if (op_i == fdm_pkg::OP_INIT) begin
              done_q <= 1'b1;
              mob_q  <= '0;
              deg_q  <= '0;
              lvo_q  <= {8'b0, init_level_i};
              fto_q  <= 1'b0;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          a_q     <= prod_a[48:16];
          aold_q  <= prod_b[48:16];
          lvl_q   <= rd_q[fdm_pkg::LEVEL_W-1:0];
          flag_q  <= rd_q[fdm_pkg::LEVEL_W];
          state_q <= S_UPD;
        end
        S_UPD: begin
          lvl_q   <= lvl_new;
          state_q <= S_DEC;
        end
        S_DEC: begin
          // write-back happens here
          flag_q <= flag_new;
          if (lvl_q < 40'(thr_q)) begin
            f_q     <= fdm_pkg::ONE_Q;
            state_q <= S_MOB;
          end else if (mode_q == fdm_pkg::MODE_ASYMPTOTIC) begin
            if ((thr_q == '0) && (lvl_q == '0)) begin
              f_q     <= fdm_pkg::ONE_Q;
              state_q <= S_MOB;
            end else begin
              rem_q   <= {thr_q, 17'b0};
              den_q   <= 41'(thr_q) + 41'(lvl_q);
              cnt_q   <= 5'd16;
              quo_q   <= '0;
              state_q <= S_DIV;
            end
          end else begin
            if (lvl_q == 40'(thr_q)) begin
              f_q     <= fdm_pkg::ONE_Q;
              state_q <= S_MOB;
            end else if (thr_q == '0) begin
              f_q     <= '0;
              state_q <= S_MOB;
            end else begin
              norm_q  <= lvl_q;
              shcnt_q <= '0;
              which_q <= 1'b0;
              state_q <= S_NORM;
            end
          end
        end
        S_DIV: begin
          if (div_ge) begin
            rem_q <= rem_q - den_sh[48:0];
            quo_q <= quo_q | (fdm_pkg::FAC_W'(1) << cnt_q);
          end
          if (cnt_q == '0) begin
            sq_q    <= quo_q | fdm_pkg::FAC_W'(div_ge);
            state_q <= S_FSQ;
          end
          cnt_q <= cnt_q - 1'b1;
        end
        S_NORM: begin
          // left-justify, a byte at a time then a bit at a time
          if (norm_q[39:32] == '0) begin
            norm_q  <= norm_q << 8;
            shcnt_q <= shcnt_q + 6'd8;
          end else if (!norm_q[39]) begin
            norm_q  <= norm_q << 1;
            shcnt_q <= shcnt_q + 6'd1;
          end else begin
            m_q     <= norm_q[39:9];
            frac_q  <= '0;
            cnt_q   <= '0;
            state_q <= S_LOGSQ;
          end
        end
        S_LOGSQ: begin
          m_q    <= frac_bit ? msq_s[31:1] : msq_s[30:0];
          frac_q <= {frac_q[14:0], frac_bit};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == 5'd15) begin
            if (!which_q) begin
              la_q    <= log_val;
              norm_q  <= 40'(thr_q);
              shcnt_q <= '0;
              which_q <= 1'b1;
              state_q <= S_NORM;
            end else begin
              lb_q    <= log_val;
              state_q <= S_D2;
            end
          end
        end
        S_D2: begin
          d2_q    <= (la_q > lb_q) ? (la_q - lb_q) : '0;
          state_q <= S_D10;
        end
        S_D10: begin
          d10_q   <= d10_prod[53:32];
          state_q <= S_DROP;
        end
        S_DROP: begin
          sq_q    <= (drop >= 30'(fdm_pkg::ONE_Q)) ? '0
                     : fdm_pkg::ONE_Q - drop[fdm_pkg::FAC_W-1:0];
          state_q <= S_FSQ;
        end
        S_FSQ: begin
          f_q     <= fsq[32:16];
          state_q <= S_MOB;
        end
        S_MOB: begin
          done_q  <= 1'b1;
          mob_q   <= mob_prod[47:16];
          deg_q   <= f_q;
          lvo_q   <= lvl_q;
          fto_q   <= flag_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o        = done_q;
  assign mobility_o    = mob_q;
  assign degradation_o = deg_q;
  assign level_o       = lvo_q;
  assign fatigued_o    = fto_q;

endmodule
